// File: design/text_console_writer_macros.svh
// ----------------------------------------------------------------------------
// text_console_writer_macros
// Assertion macros used by the console RTL (tcw_back).
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// same-cycle implication
`define TCW_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants of the text console writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

   localparam logic [1:0] OP_PUT_CHAR    = 2'd0;
   localparam logic [1:0] OP_MOVE_CURSOR = 2'd1;
   localparam logic [1:0] OP_CLEAR       = 2'd2;
   localparam logic [1:0] OP_READ_CELL   = 2'd3;

   localparam logic [7:0] BLANK_CHAR   = 8'd32;
   localparam logic [7:0] NEWLINE_CHAR = 8'd10;
   localparam logic [7:0] RESET_ATTR   = 8'd15;

   localparam logic REG_TEXT_ATTR = 1'b0;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] char_code;
      logic [6:0] column;
      logic [4:0] line;
   } req_type;

   typedef struct packed {
      logic [6:0] cursor_column;
      logic [4:0] cursor_line;
      logic       did_scroll;
      logic [7:0] cell_char;
      logic [7:0] cell_attr;
   } rsp_type;

   // classified request, position already clamped
   typedef struct packed {
      logic [1:0] op;
      logic [7:0] char_code;
      logic       newline;
      logic [6:0] column;
      logic [4:0] line;
   } cmd_type;

   typedef struct packed {
      logic pop;
      logic init;
   } back_ctl_type;

endpackage

// File: design/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                                         clock,
   input  logic                                         we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                             wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                             rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: design/tcw_queue.sv
// ----------------------------------------------------------------------------
// tcw_queue
// Small register queue with fill count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty,
   output logic             full
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: design/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Accepts requests, clamps positions, flags newlines, queues commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_front #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  tcw_pkg::req_type      req_item,
   input  tcw_pkg::back_ctl_type ctl,
   output logic                  cmd_valid,
   output tcw_pkg::cmd_type      cmd_head
);

   tcw_pkg::cmd_type                    cmd_d;
   logic [$bits(tcw_pkg::cmd_type)-1:0] q_rdata;
   logic                                q_empty, q_full;

   always_comb begin
      cmd_d.op        = req_item.operation;
      cmd_d.char_code = req_item.char_code;
      cmd_d.newline   = (req_item.char_code == tcw_pkg::NEWLINE_CHAR);
      cmd_d.column    = (int'(req_item.column) >= COLUMNS) ? 7'(COLUMNS - 1)
                                                           : req_item.column;
      cmd_d.line      = (int'(req_item.line) >= ROWS) ? 5'(ROWS - 1) : req_item.line;
   end

   // no requests while the store is swept after reset
   assign full = q_full || ctl.init;

   tcw_queue #(
      .WIDTH ($bits(tcw_pkg::cmd_type)),
      .DEPTH (2)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (push && !full),
      .wdata (cmd_d),
      .pop   (ctl.pop),
      .rdata (q_rdata),
      .empty (q_empty),
      .full  (q_full)
   );

   assign cmd_valid = !q_empty;
   assign cmd_head  = q_rdata;

endmodule

// File: design/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// Executes commands against the screen store: cell writes, cursor moves,
// scroll copy and blank fill sweeps, cell reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_console_writer_macros.svh"

module tcw_back #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            text_attribute,
   input  logic                  cmd_valid,
   input  tcw_pkg::cmd_type      cmd_head,
   output tcw_pkg::back_ctl_type ctl,
   output logic                  empty,
   input  logic                  pop,
   output tcw_pkg::rsp_type      rsp_item
);

   localparam int CELLS  = ROWS * COLUMNS;
   localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  MAX_ROW   = ROW_W'(ROWS - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] BOTTOM    = ADDR_W'((ROWS - 1) * COLUMNS);
   localparam logic [ADDR_W-1:0] COL_STEP  = ADDR_W'(COLUMNS);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_EXEC     = 3'd1;
   localparam logic [2:0] ST_READ     = 3'd2;
   localparam logic [2:0] ST_COPY     = 3'd3;
   localparam logic [2:0] ST_COPY_END = 3'd4;
   localparam logic [2:0] ST_FILL     = 3'd5;

   logic [2:0]        state_ff, state_in;
   tcw_pkg::cmd_type  cmd_ff, cmd_in;
   logic [ADDR_W-1:0] tgt_addr_ff, tgt_addr_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [ADDR_W-1:0] cur_addr_ff, cur_addr_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [7:0]        fill_attr_ff, fill_attr_in;
   logic              init_ff, init_in;
   logic              scroll_ff, scroll_in;

   logic              cmd_pop;
   logic              we;
   logic [ADDR_W-1:0] waddr, raddr;
   logic [15:0]       wdata, rd_data;
   logic              rsp_push, rsp_full;
   logic [7:0]        cell_char, cell_attr;
   tcw_pkg::rsp_type  rsp_d;
   logic [$bits(tcw_pkg::rsp_type)-1:0] rsp_q;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      tgt_addr_in  = tgt_addr_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      cur_addr_in  = cur_addr_ff;
      ptr_in       = ptr_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      fill_attr_in = fill_attr_ff;
      init_in      = init_ff;
      scroll_in    = scroll_ff;
      we           = 1'b0;
      waddr        = cur_addr_ff;
      wdata        = {text_attribute, cmd_ff.char_code};
      raddr        = tgt_addr_ff;
      rsp_push     = 1'b0;
      cmd_pop      = 1'b0;
      cell_char    = '0;
      cell_attr    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !rsp_full) begin
               cmd_pop     = 1'b1;
               cmd_in      = cmd_head;
               tgt_addr_in = ADDR_W'(int'(cmd_head.line) * COLUMNS + int'(cmd_head.column));
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            scroll_in = 1'b0;
            unique case (cmd_ff.op)
               tcw_pkg::OP_PUT_CHAR: begin
                  we = !cmd_ff.newline;
                  if (cmd_ff.newline || cur_col_ff == LAST_COL) begin
                     cur_col_in = '0;
                     if (cur_row_ff == MAX_ROW) begin
                        cur_row_in   = MAX_ROW;
                        cur_addr_in  = BOTTOM;
                        scroll_in    = 1'b1;
                        fill_attr_in = text_attribute;
                        pend_in      = 1'b0;
                        if (ROWS > 1) begin
                           ptr_in   = COL_STEP;
                           state_in = ST_COPY;
                        end else begin
                           ptr_in   = BOTTOM;
                           state_in = ST_FILL;
                        end
                     end else begin
                        cur_row_in  = cur_row_ff + ROW_W'(1);
                        cur_addr_in = cmd_ff.newline
                                    ? cur_addr_ff - ADDR_W'(cur_col_ff) + COL_STEP
                                    : cur_addr_ff + ADDR_W'(1);
                        rsp_push    = 1'b1;
                        state_in    = ST_IDLE;
                     end
                  end else begin
                     cur_col_in  = cur_col_ff + COL_W'(1);
                     cur_addr_in = cur_addr_ff + ADDR_W'(1);
                     rsp_push    = 1'b1;
                     state_in    = ST_IDLE;
                  end
               end
               tcw_pkg::OP_MOVE_CURSOR: begin
                  cur_col_in  = COL_W'(cmd_ff.column);
                  cur_row_in  = ROW_W'(cmd_ff.line);
                  cur_addr_in = tgt_addr_ff;
                  rsp_push    = 1'b1;
                  state_in    = ST_IDLE;
               end
               tcw_pkg::OP_CLEAR: begin
                  cur_col_in   = '0;
                  cur_row_in   = '0;
                  cur_addr_in  = '0;
                  fill_attr_in = text_attribute;
                  ptr_in       = '0;
                  state_in     = ST_FILL;
               end
               tcw_pkg::OP_READ_CELL: begin
                  raddr    = tgt_addr_ff;
                  state_in = ST_READ;
               end
            endcase
         end
         ST_READ: begin
            cell_char = rd_data[7:0];
            cell_attr = rd_data[15:8];
            rsp_push  = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_COPY: begin
            // read one row ahead, write the previous read one row up
            raddr        = ptr_ff;
            we           = pend_ff;
            waddr        = pend_addr_ff;
            wdata        = rd_data;
            pend_in      = 1'b1;
            pend_addr_in = ptr_ff - COL_STEP;
            if (ptr_ff == LAST_ADDR) begin
               state_in = ST_COPY_END;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
         ST_COPY_END: begin
            we       = pend_ff;
            waddr    = pend_addr_ff;
            wdata    = rd_data;
            pend_in  = 1'b0;
            ptr_in   = BOTTOM;
            state_in = ST_FILL;
         end
         ST_FILL: begin
            we    = 1'b1;
            waddr = ptr_ff;
            wdata = {fill_attr_ff, tcw_pkg::BLANK_CHAR};
            if (ptr_ff == LAST_ADDR) begin
               rsp_push = !init_ff;
               init_in  = 1'b0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign ctl = '{pop: cmd_pop, init: init_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         cur_addr_ff  <= '0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         fill_attr_ff <= tcw_pkg::RESET_ATTR;
         init_ff      <= 1'b1;
         scroll_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         cur_addr_ff  <= cur_addr_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         fill_attr_ff <= fill_attr_in;
         init_ff      <= init_in;
         scroll_ff    <= scroll_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      tgt_addr_ff  <= tgt_addr_in;
      pend_addr_ff <= pend_addr_in;
   end

   tcw_ram #(
      .WIDTH (16),
      .DEPTH (CELLS)
   ) u_screen_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rd_data)
   );

   always_comb begin
      rsp_d.cursor_column = 7'(cur_col_in);
      rsp_d.cursor_line   = 5'(cur_row_in);
      rsp_d.did_scroll    = scroll_in;
      rsp_d.cell_char     = cell_char;
      rsp_d.cell_attr     = cell_attr;
   end

   tcw_queue #(
      .WIDTH ($bits(tcw_pkg::rsp_type)),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_d),
      .pop   (pop),
      .rdata (rsp_q),
      .empty (empty),
      .full  (rsp_full)
   );

   assign rsp_item = rsp_q;

   `TCW_ASSERT_IMP(a_rsp_room, clock, reset, rsp_push, !rsp_full, "response queue overrun")
   `TCW_ASSERT_NXT(a_pop_exec, clock, reset, cmd_pop, state_ff == ST_EXEC, "pop without execute")
   `TCW_ASSERT_IMP(a_cursor_range, clock, reset, 1'b1,
      (int'(cur_col_ff) < COLUMNS) && (int'(cur_row_ff) < ROWS), "cursor out of range")
   `TCW_ASSERT_IMP(a_cursor_addr, clock, reset, state_ff == ST_IDLE,
      int'(cur_addr_ff) == int'(cur_row_ff) * COLUMNS + int'(cur_col_ff),
      "cursor address mismatch")

endmodule

// File: design/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console with cursor, newline, scroll, clear and read.
// ----------------------------------------------------------------------------
// Sweeps: the copy and fill sweeps move one cell per cycle through the single write
//   port of the screen RAM; a clear or a scrolling put_char holds off later commands.
// Reset: synchronous; all ROWS*COLUMNS cells of the screen RAM (2000 by default)
//   are blanked in a fill sweep during which full stays high.
`timescale 1ns / 1ps

module text_console_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  tcw_pkg::req_type req_item,
   output logic             empty,
   input  logic             pop,
   output tcw_pkg::rsp_type rsp_item,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [7:0]            attr_ff, attr_in;
   logic                  csr_wr;
   logic                  cmd_valid;
   tcw_pkg::cmd_type      cmd_head;
   tcw_pkg::back_ctl_type ctl;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      attr_in = attr_ff;
      if (csr_wr && paddr[2] == tcw_pkg::REG_TEXT_ATTR) begin
         attr_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tcw_pkg::RESET_ATTR;
      end else begin
         attr_ff <= attr_in;
      end
   end

   assign prdata = (paddr[2] == tcw_pkg::REG_TEXT_ATTR) ? {24'd0, attr_ff} : '0;

   tcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .ctl       (ctl),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head)
   );

   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .text_attribute (attr_ff),
      .cmd_valid      (cmd_valid),
      .cmd_head       (cmd_head),
      .ctl            (ctl),
      .empty          (empty),
      .pop            (pop),
      .rsp_item       (rsp_item)
   );

endmodule
